// File: hw/rtl/dkgc_pkg.sv
// ----------------------------------------------------------------------------
// dkgc_pkg: shared types and constants for the differential key-guess counter
// Widths, register indexes, the inverse S-box and the inverse bit permutation.
// ----------------------------------------------------------------------------
`default_nettype none

package dkgc_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 17;

    localparam int CIPHER_W    = 64;
    localparam int NIBBLE_W    = 4;
    localparam int NIBBLES     = CIPHER_W / NIBBLE_W;
    localparam int GROUPS      = 6;
    localparam int GUESSES     = 16;
    localparam int LANE_W      = GROUPS * NIBBLE_W;
    localparam int POSITION_W  = 3;
    localparam int RESULT_CNT_W = 17;
    localparam int SEQ_W       = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_DIFF = 2'd1;

    localparam logic [NIBBLES-1:0]  FILTER_MASK_RESET = 16'hFAAA;
    localparam logic [NIBBLE_W-1:0] TARGET_DIFF_RESET = 4'h4;

    // Controls broadcast to every cell
    typedef struct packed {
        logic                  init;      // zero the running best
        logic                  scan;      // compare one counter against the best
        logic [SEQ_W-1:0]      scan_idx;  // guess under comparison
        logic                  clear;     // zero all counters
        logic                  shift;     // move results one cell toward the output
    } cell_ctrl_t;

    function automatic logic [NIBBLE_W-1:0] sbox_inverse(input logic [NIBBLE_W-1:0] x);
        logic [NIBBLE_W-1:0] y;
        case (x)
            4'h0:    y = 4'h5;
            4'h1:    y = 4'hE;
            4'h2:    y = 4'hF;
            4'h3:    y = 4'h8;
            4'h4:    y = 4'hC;
            4'h5:    y = 4'h1;
            4'h6:    y = 4'h2;
            4'h7:    y = 4'hD;
            4'h8:    y = 4'hB;
            4'h9:    y = 4'h4;
            4'hA:    y = 4'h6;
            4'hB:    y = 4'h3;
            4'hC:    y = 4'h0;
            4'hD:    y = 4'h7;
            4'hE:    y = 4'h9;
            4'hF:    y = 4'hA;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // Undo the PRESENT bit permutation: bit 16i mod 63 returns to bit i, bit 63 stays.
    function automatic logic [CIPHER_W-1:0] unpermute(input logic [CIPHER_W-1:0] x);
        logic [CIPHER_W-1:0] r;
        r = '0;
        for (int i = 0; i < CIPHER_W - 1; i++)
        begin
            r[i] = x[(16 * i) % (CIPHER_W - 1)];
        end
        r[CIPHER_W-1] = x[CIPHER_W-1];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dkgc_if.sv
// ----------------------------------------------------------------------------
// dkgc_if: valid/ready channels of the differential key-guess counter
// Input items (pair or report) and result items, each with source and sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface dkgc_item_if;
    import dkgc_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [CIPHER_W-1:0] first_ciphertext;
    logic [CIPHER_W-1:0] second_ciphertext;

    modport source (output valid, output mode, output first_ciphertext,
                    output second_ciphertext, input ready);
    modport sink   (input valid, input mode, input first_ciphertext,
                    input second_ciphertext, output ready);
endinterface

interface dkgc_result_if;
    import dkgc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [POSITION_W-1:0]   nibble_position;
    logic [NIBBLE_W-1:0]     best_key;
    logic [RESULT_CNT_W-1:0] best_count;
    logic [RESULT_CNT_W-1:0] pairs_kept;
    logic                    last;

    modport source (output valid, output nibble_position, output best_key,
                    output best_count, output pairs_kept, output last, input ready);
    modport sink   (input valid, input nibble_position, input best_key,
                    input best_count, input pairs_kept, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dkgc_front.sv
// ----------------------------------------------------------------------------
// dkgc_front: pair front end
// Unpermutes both ciphertexts, applies the nibble filter, counts kept pairs
// and registers the even nibbles of kept pairs for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dkgc_front #(
    parameter int COUNT_WIDTH = dkgc_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pair_accept,
    input  logic [dkgc_pkg::CIPHER_W-1:0] first_ciphertext,
    input  logic [dkgc_pkg::CIPHER_W-1:0] second_ciphertext,
    input  logic [dkgc_pkg::NIBBLES-1:0]  filter_mask,
    input  logic                          clear,
    output logic                          stage_valid,
    output logic [dkgc_pkg::LANE_W-1:0]   stage_a,
    output logic [dkgc_pkg::LANE_W-1:0]   stage_b,
    output logic [COUNT_WIDTH-1:0]        kept_count
);
    import dkgc_pkg::*;

    logic [CIPHER_W-1:0]    perm_a;
    logic [CIPHER_W-1:0]    perm_b;
    logic [NIBBLES-1:0]     nibble_ne;
    logic                   keep;
    logic [LANE_W-1:0]      even_a;
    logic [LANE_W-1:0]      even_b;

    logic                   stage_valid_reg, stage_valid_next;
    logic [LANE_W-1:0]      stage_a_reg, stage_b_reg;
    logic [COUNT_WIDTH-1:0] kept_reg, kept_next;

    always_comb
    begin
        perm_a = unpermute(first_ciphertext);
        perm_b = unpermute(second_ciphertext);
        for (int j = 0; j < NIBBLES; j++)
        begin
            nibble_ne[j] = |(perm_a[NIBBLE_W*j +: NIBBLE_W] ^ perm_b[NIBBLE_W*j +: NIBBLE_W]);
        end
        keep = ~|(filter_mask & nibble_ne);
        // gather nibbles 0, 2, ..., 10
        for (int k = 0; k < GROUPS; k++)
        begin
            even_a[NIBBLE_W*k +: NIBBLE_W] = perm_a[2*NIBBLE_W*k +: NIBBLE_W];
            even_b[NIBBLE_W*k +: NIBBLE_W] = perm_b[2*NIBBLE_W*k +: NIBBLE_W];
        end
    end

    always_comb
    begin
        stage_valid_next = pair_accept && keep;
        kept_next        = kept_reg;
        if (clear)
        begin
            kept_next = '0;
        end
        else if (stage_valid_next && (kept_reg != '1))
        begin
            kept_next = kept_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            kept_reg        <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            kept_reg        <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_accept)
        begin
            stage_a_reg <= even_a;
            stage_b_reg <= even_b;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_a     = stage_a_reg;
    assign stage_b     = stage_b_reg;
    assign kept_count  = kept_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dkgc_cell.sv
// ----------------------------------------------------------------------------
// dkgc_cell: one counted nibble
// Holds the 16 guess counters of one nibble, bumps them from the passing pair,
// hands the pair on to the next cell, finds its best guess by a scan and
// shifts results toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dkgc_cell #(
    parameter int COUNT_WIDTH = dkgc_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dkgc_pkg::cell_ctrl_t          ctrl,
    input  logic [dkgc_pkg::NIBBLE_W-1:0] target,
    input  logic                          pipe_valid,
    input  logic [dkgc_pkg::LANE_W-1:0]   pipe_a,
    input  logic [dkgc_pkg::LANE_W-1:0]   pipe_b,
    output logic                          fwd_valid,
    output logic [dkgc_pkg::LANE_W-1:0]   fwd_a,
    output logic [dkgc_pkg::LANE_W-1:0]   fwd_b,
    input  logic [dkgc_pkg::NIBBLE_W-1:0] next_key,
    input  logic [COUNT_WIDTH-1:0]        next_count,
    output logic [dkgc_pkg::NIBBLE_W-1:0] best_key,
    output logic [COUNT_WIDTH-1:0]        best_count
);
    import dkgc_pkg::*;

    logic [GUESSES-1:0]     hit;
    logic [COUNT_WIDTH-1:0] counter_reg  [GUESSES];
    logic [COUNT_WIDTH-1:0] counter_next [GUESSES];
    logic [COUNT_WIDTH-1:0] scan_value;

    logic                   fwd_valid_reg;
    logic [LANE_W-1:0]      fwd_a_reg, fwd_b_reg;
    logic [NIBBLE_W-1:0]    best_key_reg, best_key_next;
    logic [COUNT_WIDTH-1:0] best_count_reg, best_count_next;

    always_comb
    begin
        for (int g = 0; g < GUESSES; g++)
        begin
            hit[g] = (sbox_inverse(pipe_a[NIBBLE_W-1:0] ^ NIBBLE_W'(g))
                    ^ sbox_inverse(pipe_b[NIBBLE_W-1:0] ^ NIBBLE_W'(g))) == target;
            if (ctrl.clear)
            begin
                counter_next[g] = '0;
            end
            else if (pipe_valid && hit[g] && (counter_reg[g] != '1))
            begin
                counter_next[g] = counter_reg[g] + 1'b1;
            end
            else
            begin
                counter_next[g] = counter_reg[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GUESSES; g++)
            begin
                counter_reg[g] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < GUESSES; g++)
            begin
                counter_reg[g] <= counter_next[g];
            end
        end
    end

    // Strict greater with ascending guesses keeps the lowest guess on ties.
    assign scan_value = counter_reg[ctrl.scan_idx];

    always_comb
    begin
        best_key_next   = best_key_reg;
        best_count_next = best_count_reg;
        if (ctrl.init)
        begin
            best_key_next   = '0;
            best_count_next = '0;
        end
        else if (ctrl.scan && (scan_value > best_count_reg))
        begin
            best_key_next   = ctrl.scan_idx;
            best_count_next = scan_value;
        end
        else if (ctrl.shift)
        begin
            best_key_next   = next_key;
            best_count_next = next_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg  <= 1'b0;
            best_key_reg   <= '0;
            best_count_reg <= '0;
        end
        else
        begin
            fwd_valid_reg  <= pipe_valid;
            best_key_reg   <= best_key_next;
            best_count_reg <= best_count_next;
        end
    end

    // advance the pair by one nibble for the next cell
    always_ff @(posedge clk)
    begin
        fwd_a_reg <= pipe_a >> NIBBLE_W;
        fwd_b_reg <= pipe_b >> NIBBLE_W;
    end

    assign fwd_valid  = fwd_valid_reg;
    assign fwd_a      = fwd_a_reg;
    assign fwd_b      = fwd_b_reg;
    assign best_key   = best_key_reg;
    assign best_count = best_count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/differential_key_guess_counter.sv
// ----------------------------------------------------------------------------
// differential_key_guess_counter: last-round key recovery counter for PRESENT
// Counts differential hits for 16 key guesses on six even nibbles and reports
// the best guess of each nibble on request.
// ----------------------------------------------------------------------------
// A pair transaction (mode 0) is taken every cycle while the block is idle:
// both ciphertexts are unpermuted, filtered on the masked nibbles, and a kept
// pair walks down a chain of six cells, one per nibble 0, 2, ..., 10, each
// bumping its 16 saturating guess counters in the cycle after its neighbor. A
// report transaction (mode 1) stalls the input: the block waits until the
// chain is empty, scans the 16 counters of every cell in parallel (one
// compare per cell per cycle), clears all counters and the kept-pair count,
// then shifts six result transactions out of the chain, one per cycle as the
// sink takes them; the sixth carries last. A report therefore holds off the
// next input through the drain, the scan and the six result transactions,
// longer while the sink stalls. Results wait in an output register, so new
// pairs are taken while the final result is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_key_guess_counter #(
    parameter int COUNT_WIDTH = dkgc_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dkgc_item_if.sink                        items,
    dkgc_result_if.source                    results,
    input  logic                             cfg_write_en,
    input  logic [dkgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dkgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dkgc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam int EXT_W = COUNT_WIDTH + RESULT_CNT_W;

    // Configuration registers
    logic [NIBBLES-1:0]  filter_mask_reg;
    logic [NIBBLE_W-1:0] target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mask_reg <= FILTER_MASK_RESET;
            target_reg      <= TARGET_DIFF_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FILTER_MASK: filter_mask_reg <= cfg_data[NIBBLES-1:0];
                CFG_TARGET_DIFF: target_reg      <= cfg_data[NIBBLE_W-1:0];
                default:         ; // drop writes to unknown registers
            endcase
        end
    end

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             item_fire;
    logic             pair_accept;
    logic             chain_busy;
    logic             out_load;
    logic             scan_done;
    cell_ctrl_t       ctrl;

    // Chain wiring: element k feeds cell k, element GROUPS leaves the last cell
    logic                   pipe_valid [GROUPS+1];
    logic [LANE_W-1:0]      pipe_a     [GROUPS+1];
    logic [LANE_W-1:0]      pipe_b     [GROUPS+1];
    logic [NIBBLE_W-1:0]    res_key    [GROUPS+1];
    logic [COUNT_WIDTH-1:0] res_count  [GROUPS+1];
    logic [COUNT_WIDTH-1:0] kept_count;
    logic [COUNT_WIDTH-1:0] kept_snap_reg;

    assign items.ready = (state_reg == ST_IDLE);
    assign item_fire   = items.valid && items.ready;
    assign pair_accept = item_fire && !items.mode;

    always_comb
    begin
        chain_busy = 1'b0;
        for (int k = 0; k <= GROUPS; k++)
        begin
            chain_busy = chain_busy | pipe_valid[k];
        end
    end

    assign scan_done = (state_reg == ST_SCAN) && (seq_reg == SEQ_W'(GUESSES - 1));
    assign out_load  = (state_reg == ST_OUT) && (!results.valid || results.ready);

    always_comb
    begin
        ctrl.init     = (state_reg == ST_DRAIN);
        ctrl.scan     = (state_reg == ST_SCAN);
        ctrl.scan_idx = seq_reg;
        ctrl.clear    = scan_done;
        ctrl.shift    = out_load;
    end

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && items.mode)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // hold until no pair is left in the chain
                if (!chain_busy)
                begin
                    state_next = ST_SCAN;
                    seq_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_OUT;
                    seq_next   = '0;
                end
                else
                begin
                    seq_next = seq_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    if (seq_reg == SEQ_W'(GROUPS - 1))
                    begin
                        state_next = ST_IDLE;
                        seq_next   = '0;
                    end
                    else
                    begin
                        seq_next = seq_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                seq_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    // Keep the kept-pair count of this report while the live count is cleared
    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            kept_snap_reg <= kept_count;
        end
    end

    dkgc_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .pair_accept       (pair_accept),
        .first_ciphertext  (items.first_ciphertext),
        .second_ciphertext (items.second_ciphertext),
        .filter_mask       (filter_mask_reg),
        .clear             (scan_done),
        .stage_valid       (pipe_valid[0]),
        .stage_a           (pipe_a[0]),
        .stage_b           (pipe_b[0]),
        .kept_count        (kept_count)
    );

    // The last cell shifts in an empty result
    assign res_key[GROUPS]   = '0;
    assign res_count[GROUPS] = '0;

    for (genvar k = 0; k < GROUPS; k++)
    begin : g_cell
        dkgc_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .target     (target_reg),
            .pipe_valid (pipe_valid[k]),
            .pipe_a     (pipe_a[k]),
            .pipe_b     (pipe_b[k]),
            .fwd_valid  (pipe_valid[k+1]),
            .fwd_a      (pipe_a[k+1]),
            .fwd_b      (pipe_b[k+1]),
            .next_key   (res_key[k+1]),
            .next_count (res_count[k+1]),
            .best_key   (res_key[k]),
            .best_count (res_count[k])
        );
    end

    // Output register: fields cut or zero-extended to the result width
    logic                    out_valid_reg, out_valid_next;
    logic [POSITION_W-1:0]   out_pos_reg;
    logic [NIBBLE_W-1:0]     out_key_reg;
    logic [RESULT_CNT_W-1:0] out_count_reg;
    logic [RESULT_CNT_W-1:0] out_kept_reg;
    logic                    out_last_reg;
    logic [EXT_W-1:0]        best_ext;
    logic [EXT_W-1:0]        kept_ext;

    assign best_ext = {{RESULT_CNT_W{1'b0}}, res_count[0]};
    assign kept_ext = {{RESULT_CNT_W{1'b0}}, kept_snap_reg};

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pos_reg   <= seq_reg[POSITION_W-1:0];
            out_key_reg   <= res_key[0];
            out_count_reg <= best_ext[RESULT_CNT_W-1:0];
            out_kept_reg  <= kept_ext[RESULT_CNT_W-1:0];
            out_last_reg  <= (seq_reg == SEQ_W'(GROUPS - 1));
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.nibble_position = out_pos_reg;
    assign results.best_key        = out_key_reg;
    assign results.best_count      = out_count_reg;
    assign results.pairs_kept      = out_kept_reg;
    assign results.last            = out_last_reg;

endmodule

`default_nettype wire
